### design/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds in the same cycle: whenever pre is true, post must be true.
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-edge form: whenever pre is true, post must be true at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

### design/sbac_pkg.sv
// Shared constants, codes and stage flag type for the swept box axis clip block.
package sbac_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_INDEX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_X_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_Y_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_Z_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_X_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_Y_HIGH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVER_Z_HIGH = 3'd5;

  // Axis select codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Per-item decisions carried down the pipeline.
  typedef struct packed {
    logic strict;
    logic touch;
    logic clip_pos;
    logic clip_neg;
  } clip_flags_t;

endpackage

### design/sbac_cmp.sv
// First stage: per-axis box compares, axis selection and gap operand choice.
module sbac_cmp import sbac_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    axis,
  input  logic signed [COORD_WIDTH-1:0] obs_low  [3],
  input  logic signed [COORD_WIDTH-1:0] obs_high [3],
  input  logic signed [COORD_WIDTH-1:0] move,
  input  logic signed [COORD_WIDTH-1:0] mov_low  [3],
  input  logic signed [COORD_WIDTH-1:0] mov_high [3],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_a,
  output logic signed [COORD_WIDTH-1:0] out_b,
  output logic signed [COORD_WIDTH-1:0] out_move,
  output clip_flags_t                   out_flags
);

  logic [2:0]  strict_ax;
  logic [2:0]  touch_ax;
  logic [2:0]  below;
  logic [2:0]  above;
  logic        cross_ok;
  logic [1:0]  ax_idx;
  logic        move_pos;
  logic        move_neg;
  logic        valid_r;
  logic        valid_nxt;
  logic signed [COORD_WIDTH-1:0] a_r, a_nxt;
  logic signed [COORD_WIDTH-1:0] b_r, b_nxt;
  logic signed [COORD_WIDTH-1:0] move_r;
  clip_flags_t flags_r, flags_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      strict_ax[i] = (mov_high[i] > obs_low[i]) && (mov_low[i] < obs_high[i]);
      touch_ax[i]  = (mov_high[i] >= obs_low[i]) && (mov_low[i] <= obs_high[i]);
      below[i]     = mov_high[i] <= obs_low[i];
      above[i]     = mov_low[i] >= obs_high[i];
    end
  end

  // Clipping needs strict overlap on the two axes other than the moving one.
  always_comb begin
    case (axis)
      AXIS_X: begin
        cross_ok = strict_ax[1] && strict_ax[2];
        ax_idx   = AXIS_X;
      end
      AXIS_Y: begin
        cross_ok = strict_ax[2] && strict_ax[0];
        ax_idx   = AXIS_Y;
      end
      AXIS_Z: begin
        cross_ok = strict_ax[0] && strict_ax[1];
        ax_idx   = AXIS_Z;
      end
      default: begin
        cross_ok = 1'b0;
        ax_idx   = AXIS_X;
      end
    endcase
  end

  assign move_neg = move[COORD_WIDTH-1];
  assign move_pos = !move_neg && (move != '0);

  // The gap is always a - b: obstacle low minus mover high for a forward move,
  // mover low minus obstacle high for a backward move.
  always_comb begin
    flags_nxt.strict   = &strict_ax;
    flags_nxt.touch    = &touch_ax;
    flags_nxt.clip_pos = cross_ok && move_pos && below[ax_idx];
    flags_nxt.clip_neg = cross_ok && move_neg && above[ax_idx];
    a_nxt = move_neg ? mov_low[ax_idx]  : obs_low[ax_idx];
    b_nxt = move_neg ? obs_high[ax_idx] : mov_high[ax_idx];
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      move_r  <= move;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_move  = move_r;
  assign out_flags = flags_r;

endmodule

### design/sbac_gap.sv
// Second stage: gap subtraction and move magnitude.
module sbac_gap import sbac_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  input  logic signed [COORD_WIDTH-1:0] move,
  input  clip_flags_t                   flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_gap,
  output logic [COORD_WIDTH-1:0]        out_mag,
  output logic signed [COORD_WIDTH-1:0] out_move,
  output clip_flags_t                   out_flags
);

  logic [COORD_WIDTH:0]   gap_full;
  logic                   valid_r;
  logic                   valid_nxt;
  logic [COORD_WIDTH-1:0] gap_r, gap_nxt;
  logic [COORD_WIDTH-1:0] mag_r, mag_nxt;
  logic signed [COORD_WIDTH-1:0] move_r;
  clip_flags_t            flags_r;

  // The gap is non-negative whenever a clip flag is set, so it fits unsigned.
  assign gap_full = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  assign gap_nxt  = gap_full[COORD_WIDTH-1:0];
  assign mag_nxt  = move[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - COORD_WIDTH'(move))
                                        : COORD_WIDTH'(move);

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      gap_r   <= gap_nxt;
      mag_r   <= mag_nxt;
      move_r  <= move;
      flags_r <= flags;
    end
  end

  assign out_valid = valid_r;
  assign out_gap   = gap_r;
  assign out_mag   = mag_r;
  assign out_move  = move_r;
  assign out_flags = flags_r;

endmodule

### design/sbac_sel.sv
// Third stage: gap against magnitude compare, result select and output register.
module sbac_sel import sbac_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_WIDTH-1:0]        gap,
  input  logic [COORD_WIDTH-1:0]        mag,
  input  logic signed [COORD_WIDTH-1:0] move,
  input  clip_flags_t                   flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_clipped,
  output logic                          out_strict,
  output logic                          out_touch
);

  logic                   take;
  logic                   valid_r;
  logic                   valid_nxt;
  logic [COORD_WIDTH-1:0] clipped_r, clipped_nxt;
  logic                   strict_r;
  logic                   touch_r;

  assign take = (flags.clip_pos || flags.clip_neg) && (gap < mag);

  always_comb begin
    if (!take) begin
      clipped_nxt = COORD_WIDTH'(move);
    end else if (flags.clip_neg) begin
      clipped_nxt = COORD_WIDTH'(0) - gap;
    end else begin
      clipped_nxt = gap;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      clipped_r <= clipped_nxt;
      strict_r  <= flags.strict;
      touch_r   <= flags.touch;
    end
  end

  assign out_valid   = valid_r;
  assign out_clipped = $signed(clipped_r);
  assign out_strict  = strict_r;
  assign out_touch   = touch_r;

endmodule

### design/swept_box_axis_clip.sv
// Top level of the swept box axis clip: configuration registers and a three-stage pipeline.
// An accepted item is registered by the compare, subtract and select stages in turn.
// Throughput: one item per cycle while out_tready is high; each stage holds one item.
// A stall on the output backs up stage by stage; in_tready drops only with all stages full.
// Reset (rst_n low, synchronous) empties the pipeline and clears all mover bounds to zero.
`include "assert_macros.svh"
module swept_box_axis_clip import sbac_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((7 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((COORD_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Low bit up: obstacle_x_low, obstacle_y_low, obstacle_z_low, obstacle_x_high,
  // obstacle_y_high, obstacle_z_high, move_amount, zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type.
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Low bit up: clipped_move, overlap_strict, overlap_touching, zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  logic signed [COORD_WIDTH-1:0] mover_low_r  [3];
  logic signed [COORD_WIDTH-1:0] mover_high_r [3];
  logic signed [COORD_WIDTH-1:0] obs_low  [3];
  logic signed [COORD_WIDTH-1:0] obs_high [3];
  logic signed [COORD_WIDTH-1:0] move_amount;

  logic                          s1_valid, s1_ready;
  logic signed [COORD_WIDTH-1:0] s1_a, s1_b, s1_move;
  clip_flags_t                   s1_flags;
  logic                          s2_valid, s2_ready;
  logic [COORD_WIDTH-1:0]        s2_gap, s2_mag;
  logic signed [COORD_WIDTH-1:0] s2_move;
  clip_flags_t                   s2_flags;
  logic signed [COORD_WIDTH-1:0] clipped_move;
  logic                          overlap_strict;
  logic                          overlap_touching;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mover_low_r[i]  <= '0;
        mover_high_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOVER_X_LOW:  mover_low_r[0]  <= $signed(cfg_data);
        REG_MOVER_Y_LOW:  mover_low_r[1]  <= $signed(cfg_data);
        REG_MOVER_Z_LOW:  mover_low_r[2]  <= $signed(cfg_data);
        REG_MOVER_X_HIGH: mover_high_r[0] <= $signed(cfg_data);
        REG_MOVER_Y_HIGH: mover_high_r[1] <= $signed(cfg_data);
        REG_MOVER_Z_HIGH: mover_high_r[2] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      obs_low[i]  = $signed(in_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
      obs_high[i] = $signed(in_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH]);
    end
    move_amount = $signed(in_tdata[6*COORD_WIDTH +: COORD_WIDTH]);
  end

  sbac_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .axis      (in_tuser),
    .obs_low   (obs_low),
    .obs_high  (obs_high),
    .move      (move_amount),
    .mov_low   (mover_low_r),
    .mov_high  (mover_high_r),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_a     (s1_a),
    .out_b     (s1_b),
    .out_move  (s1_move),
    .out_flags (s1_flags)
  );

  sbac_gap #(.COORD_WIDTH(COORD_WIDTH)) u_gap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .a         (s1_a),
    .b         (s1_b),
    .move      (s1_move),
    .flags     (s1_flags),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_gap   (s2_gap),
    .out_mag   (s2_mag),
    .out_move  (s2_move),
    .out_flags (s2_flags)
  );

  sbac_sel #(.COORD_WIDTH(COORD_WIDTH)) u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .gap         (s2_gap),
    .mag         (s2_mag),
    .move        (s2_move),
    .flags       (s2_flags),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_clipped (clipped_move),
    .out_strict  (overlap_strict),
    .out_touch   (overlap_touching)
  );

  always_comb begin
    out_tdata                  = '0;
    out_tdata[COORD_WIDTH-1:0] = clipped_move;
    out_tdata[COORD_WIDTH]     = overlap_strict;
    out_tdata[COORD_WIDTH+1]   = overlap_touching;
  end

  // Strict overlap on all axes always implies touching overlap.
  `ASSERT_SAME(a_strict_touch, clk, rst_n, out_tvalid, !overlap_strict || overlap_touching)
  // The input side only stalls when every stage holds an item and the output is blocked.
  `ASSERT_SAME(a_stall_full, clk, rst_n, !in_tready, s1_valid && s2_valid && out_tvalid && !out_tready)
  // An accepted item occupies the first stage at the next edge.
  `ASSERT_NEXT(a_accept_s1, clk, rst_n, in_tvalid && in_tready, s1_valid)

endmodule

### dv/testbench.sv
// Self-checking testbench for the swept box axis clip with random stimulus and flow control.
module testbench import sbac_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W     = COORD_WIDTH_DEF;
  localparam int IN_W        = ((7 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W       = ((COORD_W + 2 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_IDLE    = 14;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 94;

  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [COORD_W-1:0] move;
    logic               overlap_strict;
    logic               overlap_touching;
  } clip_result_t;

  class clip_scoreboard;
    logic signed [COORD_W-1:0] box_low[3];
    logic signed [COORD_W-1:0] box_high[3];
    clip_result_t pending_clips[$];
    int mismatches;

    function new();
      for (int k = 0; k < 3; k++) begin
        box_low[k] = '0;
        box_high[k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
      case (idx)
        REG_MOVER_X_LOW: box_low[0] = val;
        REG_MOVER_Y_LOW: box_low[1] = val;
        REG_MOVER_Z_LOW: box_low[2] = val;
        REG_MOVER_X_HIGH: box_high[0] = val;
        REG_MOVER_Y_HIGH: box_high[1] = val;
        REG_MOVER_Z_HIGH: box_high[2] = val;
        default: ;
      endcase
    endfunction

    function logic signed [63:0] widen(logic signed [COORD_W-1:0] v);
      return {{(64 - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function int pending_count();
      return pending_clips.size();
    endfunction

    function void note_obstacle(logic [1:0] axis, logic [IN_W-1:0] data);
      logic signed [COORD_W-1:0] ol[3];
      logic signed [COORD_W-1:0] oh[3];
      logic signed [COORD_W-1:0] mv;
      logic signed [63:0] gap, mag, neg;
      logic hit[3];
      clip_result_t r;
      int a;
      a = int'(axis);
      for (int k = 0; k < 3; k++) begin
        ol[k] = data[COORD_W * k +: COORD_W];
        oh[k] = data[COORD_W * (3 + k) +: COORD_W];
      end
      mv = data[COORD_W * 6 +: COORD_W];
      r.move = mv;
      r.overlap_strict = 1'b1;
      r.overlap_touching = 1'b1;
      for (int k = 0; k < 3; k++) begin
        hit[k] = (box_high[k] > ol[k]) && (box_low[k] < oh[k]);
        if (!hit[k]) r.overlap_strict = 1'b0;
        if (!((box_high[k] >= ol[k]) && (box_low[k] <= oh[k]))) r.overlap_touching = 1'b0;
      end
      // Clipping only applies when the other two axes overlap strictly.
      if (a <= int'(AXIS_Z) && hit[(a + 1) % 3] && hit[(a + 2) % 3]) begin
        if (mv > 0 && box_high[a] <= ol[a]) begin
          gap = widen(ol[a]) - widen(box_high[a]);
          mag = widen(mv);
          if (gap < mag) r.move = gap[COORD_W-1:0];
        end else if (mv < 0 && box_low[a] >= oh[a]) begin
          gap = widen(box_low[a]) - widen(oh[a]);
          mag = -widen(mv);
          neg = -gap;
          if (gap < mag) r.move = neg[COORD_W-1:0];
        end
      end
      pending_clips.push_back(r);
    endfunction

    function void report(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_clip(logic [OUT_W-1:0] d);
      clip_result_t want;
      if (pending_clips.size() == 0) begin
        report("unexpected item, tdata", '0, d[COORD_W-1:0]);
        return;
      end
      want = pending_clips.pop_front();
      if (d[COORD_W-1:0] !== want.move)
        report("clipped_move", want.move, d[COORD_W-1:0]);
      if (d[COORD_W] !== want.overlap_strict)
        report("overlap_strict", COORD_W'(want.overlap_strict), COORD_W'(d[COORD_W]));
      if (d[COORD_W+1] !== want.overlap_touching)
        report("overlap_touching", COORD_W'(want.overlap_touching), COORD_W'(d[COORD_W+1]));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_W-1:0]       out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COORD_W-1:0]     cfg_data;

  clip_scoreboard sb;
  logic signed [COORD_W-1:0] mover_lo[3];
  logic signed [COORD_W-1:0] mover_hi[3];
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_asked = 0;
  int hold_done = 0;
  int cycle_count = 0;

  swept_box_axis_clip uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_obstacle(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_clip(out_tdata);
    end
  end

  // Result side: a random stall before each item when recv_idle is set, or one long hold when asked for.
  initial begin : receiver
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic int upto(int span);
    return int'($urandom_range(0, span));
  endfunction

  task automatic send_item(logic [1:0] axis, logic [IN_W-1:0] data);
    int gap;
    gap = send_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= axis;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_box(logic [1:0] axis,
                          logic signed [COORD_W-1:0] xl, yl, zl, xh, yh, zh, mv);
    send_item(axis, {mv, zh, yh, xh, zl, yl, xl});
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_mover(bit spare);
    wait_drained();
    write_reg(REG_MOVER_X_LOW, mover_lo[0]);
    write_reg(REG_MOVER_Y_LOW, mover_lo[1]);
    write_reg(REG_MOVER_Z_LOW, mover_lo[2]);
    write_reg(REG_MOVER_X_HIGH, mover_hi[0]);
    write_reg(REG_MOVER_Y_HIGH, mover_hi[1]);
    write_reg(REG_MOVER_Z_HIGH, mover_hi[2]);
    // Indexes past the last register must leave the box alone.
    if (spare) begin
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly an obstacle placed ahead of or behind the mover on the moving axis, with the
  // other axes overlapping, so that clipping really happens; the rest is plain noise.
  task automatic random_obstacle(int span);
    logic signed [COORD_W-1:0] ol[3];
    logic signed [COORD_W-1:0] oh[3];
    logic signed [COORD_W-1:0] mv;
    logic [1:0] axis;
    bit ahead;
    int mag;
    axis = ($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
    ahead = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      for (int k = 0; k < 3; k++) begin
        ol[k] = $urandom;
        oh[k] = $urandom;
      end
      mv = $urandom;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (k == int'(axis)) begin
          if (ahead) begin
            ol[k] = mover_hi[k] + upto(span);
            oh[k] = ol[k] + upto(span);
          end else begin
            oh[k] = mover_lo[k] - upto(span);
            ol[k] = oh[k] - upto(span);
          end
        end else begin
          case ($urandom_range(0, 7))
            0: begin
              ol[k] = mover_hi[k];
              oh[k] = ol[k] + upto(span);
            end
            1: begin
              oh[k] = mover_lo[k];
              ol[k] = oh[k] - upto(span);
            end
            2: begin
              ol[k] = mover_lo[k] + upto(span) - upto(span);
              oh[k] = mover_hi[k] + upto(span) - upto(span);
            end
            default: begin
              ol[k] = mover_lo[k] - 1 - upto(span);
              oh[k] = mover_hi[k] + 1 + upto(span);
            end
          endcase
        end
      end
      mag = upto(2 * span);
      if ($urandom_range(0, 3) == 0) ahead = !ahead;
      mv = ahead ? mag : -mag;
      case ($urandom_range(0, 19))
        0: mv = COORD_MAX;
        1: mv = COORD_MIN;
        2: mv = '0;
        default: ;
      endcase
    end
    send_box(axis, ol[0], ol[1], ol[2], oh[0], oh[1], oh[2], mv);
  endtask

  initial begin : stimulus
    logic signed [COORD_W-1:0] c;
    int size;
    int span;
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int k = 0; k < 3; k++) begin
      mover_lo[k] = '0;
      mover_hi[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset box: a point at the origin.
    send_box(AXIS_X, 32'sh10, -32'sh1, -32'sh1, 32'sh20, 32'sh1, 32'sh1, 32'sh40);
    send_box(AXIS_X, -32'sh20, -32'sh1, -32'sh1, -32'sh10, 32'sh1, 32'sh1, -32'sh5);

    mover_lo[0] = 32'sh1000;
    mover_lo[1] = 32'sh2000;
    mover_lo[2] = -32'sh3000;
    mover_hi[0] = 32'sh5000;
    mover_hi[1] = 32'sh6000;
    mover_hi[2] = 32'sh1000;
    load_mover(1'b1);
    // Obstacle ahead on x: cut, not cut, exactly the gap; then one behind on x, cut.
    send_box(AXIS_X, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh5000);
    send_box(AXIS_X, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh2000);
    send_box(AXIS_X, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh3000);
    send_box(AXIS_X, -32'sh4000, 32'sh1000, -32'sh4000, -32'sh1000, 32'sh7000, 32'sh2000,
             -32'sh5000);
    // Moving away from the obstacle, and standing still.
    send_box(AXIS_X, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             -32'sh5000);
    send_box(AXIS_X, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh0);
    // Faces already in contact on the moving axis, then gaps on z with extreme moves.
    send_box(AXIS_Y, 32'sh0, 32'sh6000, -32'sh4000, 32'sh6000, 32'sh8000, 32'sh2000,
             32'sh1000);
    send_box(AXIS_Y, 32'sh0, -32'sh1000, -32'sh4000, 32'sh6000, 32'sh2000, 32'sh2000,
             -32'sh1);
    send_box(AXIS_Z, 32'sh0, 32'sh1000, 32'sh3000, 32'sh6000, 32'sh7000, 32'sh4000,
             COORD_MAX);
    send_box(AXIS_Z, 32'sh0, 32'sh1000, -32'sh8000, 32'sh6000, 32'sh7000, -32'sh5000,
             COORD_MIN);
    // Touching on y, overlapping on x, x faces in contact (cut to zero), and no axis.
    send_box(AXIS_X, 32'sh8000, 32'sh6000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh5000);
    send_box(AXIS_X, 32'sh0, 32'sh1000, -32'sh4000, 32'sh6000, 32'sh7000, 32'sh2000,
             32'sh5000);
    send_box(AXIS_X, 32'sh5000, 32'sh1000, -32'sh4000, 32'sh6000, 32'sh7000, 32'sh2000,
             32'sh1000);
    send_box(AXIS_NONE, 32'sh8000, 32'sh1000, -32'sh4000, 32'sh9000, 32'sh7000, 32'sh2000,
             32'sh5000);
    // Inverted obstacle on the moving axis, then boxes at the extremes of the range.
    send_box(AXIS_X, 32'sh9000, 32'sh1000, -32'sh4000, 32'sh8000, 32'sh7000, 32'sh2000,
             32'sh5000);
    send_box(AXIS_X, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX);
    send_box(AXIS_Y, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MIN);
    send_box(AXIS_Z, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
             COORD_MAX);

    for (int k = 0; k < 3; k++) begin
      mover_lo[k] = COORD_MAX;
      mover_hi[k] = COORD_MIN;
    end
    load_mover(1'b0);
    send_box(AXIS_X, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX);
    send_box(AXIS_Z, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
             COORD_MIN);

    for (int p = 0; p < PHASES; p++) begin
      c = $signed($urandom) >>> 3;
      for (int k = 0; k < 3; k++) begin
        size = upto(1 << ($urandom_range(0, 4) * 5));
        case (p)
          0: begin
            mover_lo[k] = COORD_MIN;
            mover_hi[k] = COORD_MAX;
          end
          1: begin
            mover_lo[k] = COORD_MAX;
            mover_hi[k] = COORD_MAX;
          end
          2: begin
            mover_lo[k] = c + size;
            mover_hi[k] = c - size;
          end
          default: begin
            mover_lo[k] = c - size;
            mover_hi[k] = c + size;
          end
        endcase
      end
      load_mover(p == 4);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (p == 3) begin
        // Receiver holds off while items keep coming, so the pipeline backs up.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_asked++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 2))
          0: span = 15;
          1: span = 4096;
          default: span = 1 << 20;
        endcase
        random_obstacle(span);
      end
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### swept_box_axis_clip.f
+incdir+design
design/sbac_pkg.sv
design/sbac_cmp.sv
design/sbac_gap.sv
design/sbac_sel.sv
design/swept_box_axis_clip.sv
dv/testbench.sv
